@@ design/assert_macros.svh @@
// assertion helpers shared by the rtl files
// every check is clocked on aclk and held off while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

@@ design/rgbd_pkg.sv @@
// shared types, codes and tables of the 4-bit rgb dither block
// no dependencies
package rgbd_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int ERROR_BITS_DEF = 12;

    localparam logic [1:0] OP_PIXEL     = 2'd0;
    localparam logic [1:0] OP_BEGIN_ROW = 2'd1;
    localparam logic [1:0] OP_END_ROW   = 2'd2;
    localparam logic [1:0] OP_SPRITE    = 2'd3;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_BAYER = 2'd1;
    localparam logic [1:0] MODE_FS    = 2'd2;

    localparam logic REG_DITHER_MODE = 1'b0;
    localparam logic REG_LINE_WIDTH  = 1'b1;

    localparam logic [9:0] LINE_WIDTH_RST = 10'd512;

    localparam logic [1:0] TGT_CUR_RIGHT  = 2'd0;
    localparam logic [1:0] TGT_NXT_LEFT   = 2'd1;
    localparam logic [1:0] TGT_NXT_CENTER = 2'd2;
    localparam logic [1:0] TGT_NXT_RIGHT  = 2'd3;

    localparam logic [3:0] BAYER_TABLE [4][4] = '{
        '{4'd0,  4'd8,  4'd2,  4'd10},
        '{4'd12, 4'd4,  4'd14, 4'd6 },
        '{4'd3,  4'd11, 4'd1,  4'd9 },
        '{4'd15, 4'd7,  4'd13, 4'd5 }
    };

    typedef struct packed {
        logic [1:0]  opcode;
        logic [8:0]  column;
        logic [11:0] row_index;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } in_t;

    typedef struct packed {
        logic [3:0] red_out;
        logic [3:0] green_out;
        logic [3:0] blue_out;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic       load_item;
        logic       plain_out;
        logic       latch_phase;
        logic       zero_phase;
        logic       toggle_sel;
        logic       clr_en;
        logic       clr_half;
        logic       rd_cur;
        logic       quant;
        logic       rd_tgt;
        logic       wr_tgt;
        logic [1:0] tgt;
        logic       fs_out;
    } cmd_t;

    // truncate, or bayer ordered rounding with clamp
    function automatic logic [3:0] plain_quant(input logic [7:0] v, input logic bayer,
                                               input logic [1:0] phase,
                                               input logic [1:0] col);
        logic [4:0] q;
        q = {1'b0, v[7:4]};
        if (bayer && (v[3:0] > BAYER_TABLE[phase][col])) begin
            q = q + 5'd1;
        end
        return (q > 5'd15) ? 4'd15 : q[3:0];
    endfunction

endpackage

@@ design/rgbd_ctrl.sv @@
// sequencer of the dither block: handshakes, store clearing, error spreading steps
// depends on rgbd_pkg and assert_macros.svh
`include "assert_macros.svh"
module rgbd_ctrl #(
    parameter int MAX_WIDTH = rgbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      opcode,
    input  logic                            m_ready,
    output logic                            m_valid,
    input  logic [1:0]                      dither_mode,
    output rgbd_pkg::cmd_t                  cmd,
    output logic [$clog2(2*MAX_WIDTH)-1:0]  clr_idx
);
    import rgbd_pkg::*;

    localparam int AW = $clog2(2*MAX_WIDTH);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_RD_CUR, ST_QUANT, ST_RD_TGT, ST_WR_TGT, ST_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          half_reg, half_next;
    logic [1:0]    tgt_reg, tgt_next;
    logic          m_valid_reg, m_valid_next;
    logic          acc, is_fs, slot_free;
    logic [AW-1:0] last;

    assign is_fs     = (dither_mode == MODE_FS);
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && ((opcode != OP_PIXEL) || is_fs || slot_free);
    assign acc       = s_valid && s_ready;
    assign last      = half_reg ? AW'(MAX_WIDTH - 1) : AW'(2*MAX_WIDTH - 1);
    assign m_valid   = m_valid_reg;
    assign clr_idx   = cnt_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        half_next  = half_reg;
        tgt_next   = tgt_reg;
        cmd.tgt    = tgt_reg;
        cmd.clr_half = half_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                cnt_next   = cnt_reg + AW'(1);
                if (cnt_reg == last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    unique case (opcode)
                        OP_PIXEL: begin
                            cmd.load_item = 1'b1;
                            if (is_fs) begin
                                state_next = ST_RD_CUR;
                            end else begin
                                cmd.plain_out = 1'b1;
                            end
                        end
                        OP_BEGIN_ROW: cmd.latch_phase = 1'b1;
                        OP_END_ROW: begin
                            if (is_fs) begin
                                cmd.toggle_sel = 1'b1;
                                half_next      = 1'b1;
                                cnt_next       = '0;
                                state_next     = ST_CLEAR;
                            end
                        end
                        OP_SPRITE: begin
                            cmd.zero_phase = 1'b1;
                            half_next      = 1'b0;
                            cnt_next       = '0;
                            state_next     = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD_CUR: begin
                cmd.rd_cur = 1'b1;
                state_next = ST_QUANT;
            end
            ST_QUANT: begin
                cmd.quant  = 1'b1;
                tgt_next   = TGT_CUR_RIGHT;
                state_next = ST_RD_TGT;
            end
            ST_RD_TGT: begin
                cmd.rd_tgt = 1'b1;
                state_next = ST_WR_TGT;
            end
            ST_WR_TGT: begin
                cmd.wr_tgt = 1'b1;
                tgt_next   = tgt_reg + 2'd1;
                state_next = (tgt_reg == TGT_NXT_RIGHT) ? ST_DONE : ST_RD_TGT;
            end
            ST_DONE: begin
                if (slot_free) begin
                    cmd.fs_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        m_valid_next = (cmd.plain_out || cmd.fs_out) ? 1'b1
                     : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            half_reg    <= 1'b0;
            tgt_reg     <= TGT_CUR_RIGHT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            half_reg    <= half_next;
            tgt_reg     <= tgt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `ASSERT_CLK(a_ready_idle, s_ready |-> (state_reg == ST_IDLE), "ready outside idle")
    `ASSERT_NEVER(a_no_overwrite, (cmd.plain_out || cmd.fs_out) && m_valid_reg && !m_ready, "result overwritten")
    `ASSERT_CLK(a_wr_after_rd, (state_reg == ST_WR_TGT) |-> $past(state_reg == ST_RD_TGT), "write without read")

endmodule

@@ design/rgbd_datapath.sv @@
// error line store, quantizers and output register of the dither block
// depends on rgbd_pkg
module rgbd_datapath #(
    parameter int MAX_WIDTH  = rgbd_pkg::MAX_WIDTH_DEF,
    parameter int ERROR_BITS = rgbd_pkg::ERROR_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rgbd_pkg::in_t                   s_data,
    input  logic [1:0]                      dither_mode,
    input  logic [9:0]                      line_width,
    input  rgbd_pkg::cmd_t                  cmd,
    input  logic [$clog2(2*MAX_WIDTH)-1:0]  clr_idx,
    output rgbd_pkg::out_t                  m_data
);
    import rgbd_pkg::*;

    localparam int AW    = $clog2(2*MAX_WIDTH);
    localparam int EW    = ERROR_BITS;
    localparam int DEPTH = 2*MAX_WIDTH;
    localparam logic signed [EW+3:0] E_MAX = (EW+4)'((1 << (EW-1)) - 1);
    localparam logic signed [EW+3:0] E_MIN = -E_MAX - (EW+4)'(1);

    logic [3*EW-1:0] mem [DEPTH];
    logic [3*EW-1:0] rdata_reg;

    logic [1:0]  phase_reg;
    logic        sel_reg;
    logic [8:0]  col_reg;
    logic [7:0]  pix_reg [3];
    logic [3:0]  q_reg   [3];
    logic signed [EW:0] res_reg [3];
    out_t        out_reg;

    logic          in_store, right, tgt_ok;
    logic [AW-1:0] cur_base, nxt_base, col_a, cur_addr, tgt_addr, clr_addr;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          rd_en, wr_en;
    logic [3*EW-1:0] wr_data;
    logic signed [EW:0]   e_v   [3];
    logic [3:0]           q_v   [3];
    logic signed [EW:0]   r_v   [3];
    logic signed [EW+3:0] prod  [3];
    logic signed [EW+3:0] term  [3];
    logic signed [EW+3:0] sum   [3];
    logic signed [EW-1:0] sat_v [3];
    logic signed [EW-1:0] old_v [3];
    logic [2:0]           w_v;

    assign in_store = int'(col_reg) < MAX_WIDTH;
    assign right    = (int'(col_reg) + 1 < int'(line_width)) && (int'(col_reg) + 1 < MAX_WIDTH);
    assign cur_base = sel_reg ? AW'(MAX_WIDTH) : '0;
    assign nxt_base = sel_reg ? '0 : AW'(MAX_WIDTH);
    assign col_a    = AW'(col_reg);
    assign cur_addr = cur_base + col_a;
    assign clr_addr = cmd.clr_half ? (nxt_base + clr_idx) : clr_idx;

    always_comb begin
        unique case (cmd.tgt)
            TGT_CUR_RIGHT: begin
                tgt_addr = cur_base + col_a + AW'(1);
                tgt_ok   = in_store && right;
                w_v      = 3'd7;
            end
            TGT_NXT_LEFT: begin
                tgt_addr = nxt_base + col_a - AW'(1);
                tgt_ok   = in_store && (col_reg != 9'd0);
                w_v      = 3'd3;
            end
            TGT_NXT_CENTER: begin
                tgt_addr = nxt_base + col_a;
                tgt_ok   = in_store;
                w_v      = 3'd5;
            end
            default: begin
                tgt_addr = nxt_base + col_a + AW'(1);
                tgt_ok   = in_store && right;
                w_v      = 3'd1;
            end
        endcase
    end

    // per-channel quantize and spread
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            old_v[c] = rdata_reg[(3-c)*EW-1 -: EW];
            e_v[c]   = $signed({{(EW-7){1'b0}}, pix_reg[c]})
                     + (in_store ? (EW+1)'(old_v[c]) : '0);
            if (e_v[c] < 0) begin
                q_v[c] = 4'd0;
            end else if (e_v[c][EW:4] > (EW-3)'(15)) begin
                q_v[c] = 4'd15;
            end else begin
                q_v[c] = e_v[c][7:4];
            end
            r_v[c]  = e_v[c] - $signed({{(EW-7){1'b0}}, q_v[c], 4'b0000});
            prod[c] = (EW+4)'(res_reg[c]) * $signed({{(EW+1){1'b0}}, w_v});
            term[c] = (prod[c] < 0) ? ((prod[c] + (EW+4)'(15)) >>> 4) : (prod[c] >>> 4);
            sum[c]  = (EW+4)'(old_v[c]) + term[c];
            if (sum[c] > E_MAX) begin
                sat_v[c] = E_MAX[EW-1:0];
            end else if (sum[c] < E_MIN) begin
                sat_v[c] = E_MIN[EW-1:0];
            end else begin
                sat_v[c] = sum[c][EW-1:0];
            end
        end
    end

    assign rd_en   = cmd.rd_cur || cmd.rd_tgt;
    assign rd_addr = cmd.rd_cur ? cur_addr : tgt_addr;
    assign wr_en   = cmd.clr_en || (cmd.wr_tgt && tgt_ok);
    assign wr_addr = cmd.clr_en ? clr_addr : tgt_addr;
    assign wr_data = cmd.clr_en ? '0 : {sat_v[0], sat_v[1], sat_v[2]};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 2'd0;
            sel_reg   <= 1'b0;
        end else begin
            if (cmd.latch_phase) begin
                phase_reg <= s_data.row_index[1:0];
            end else if (cmd.zero_phase) begin
                phase_reg <= 2'd0;
            end
            if (cmd.toggle_sel) begin
                sel_reg <= ~sel_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            col_reg    <= s_data.column;
            pix_reg[0] <= s_data.red_in;
            pix_reg[1] <= s_data.green_in;
            pix_reg[2] <= s_data.blue_in;
        end
        if (cmd.quant) begin
            for (int c = 0; c < 3; c++) begin
                q_reg[c]   <= q_v[c];
                res_reg[c] <= r_v[c];
            end
        end
        if (cmd.plain_out) begin
            out_reg.red_out   <= plain_quant(s_data.red_in, dither_mode == MODE_BAYER,
                                             phase_reg, s_data.column[1:0]);
            out_reg.green_out <= plain_quant(s_data.green_in, dither_mode == MODE_BAYER,
                                             phase_reg, s_data.column[1:0]);
            out_reg.blue_out  <= plain_quant(s_data.blue_in, dither_mode == MODE_BAYER,
                                             phase_reg, s_data.column[1:0]);
        end else if (cmd.fs_out) begin
            out_reg <= '{red_out: q_reg[0], green_out: q_reg[1], blue_out: q_reg[2]};
        end
    end

    assign m_data = out_reg;

endmodule

@@ design/rgb_four_bit_dither_top.sv @@
// top level of the 4-bit rgb dither block: config registers, controller, datapath
// depends on rgbd_pkg, rgbd_ctrl, rgbd_datapath
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    rgbd_pkg::in_t  (opcode, column, row, rgb)
//   m_       out        m_valid/m_ready    rgbd_pkg::out_t (4-bit rgb)
//   cfg_     in         cfg_we             cfg_index, cfg_wdata
//
// pixel in none or bayer mode: the result lands in the output register on acceptance
// pixel in floyd-steinberg mode: accept, center read, quantize, then a read and a write
//   on the error line store for each of four neighbors, then output once the slot is free
// end row in floyd-steinberg mode: clearing the new next row
// start sprite and reset: clear the whole store; a stalled m_ready holds pixels in
//   none or bayer mode, control still passing; in floyd-steinberg all after a pixel
module rgb_four_bit_dither_top #(
    parameter int MAX_WIDTH  = rgbd_pkg::MAX_WIDTH_DEF,
    parameter int ERROR_BITS = rgbd_pkg::ERROR_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rgbd_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rgbd_pkg::out_t m_data,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [9:0]     cfg_wdata
);
    import rgbd_pkg::*;

    localparam int AW = $clog2(2*MAX_WIDTH);

    logic [1:0]    dither_mode_reg;
    logic [9:0]    line_width_reg;
    cmd_t          cmd;
    logic [AW-1:0] clr_idx;

    // config writes, expected only while nothing is in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dither_mode_reg <= MODE_NONE;
            line_width_reg  <= LINE_WIDTH_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DITHER_MODE: dither_mode_reg <= cfg_wdata[1:0];
                REG_LINE_WIDTH:  line_width_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer: handshakes, clear sweeps, spreading steps
    rgbd_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .opcode      (s_data.opcode),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .dither_mode (dither_mode_reg),
        .cmd         (cmd),
        .clr_idx     (clr_idx)
    );

    // error store, quantizers, output register
    rgbd_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .ERROR_BITS (ERROR_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .dither_mode (dither_mode_reg),
        .line_width  (line_width_reg),
        .cmd         (cmd),
        .clr_idx     (clr_idx),
        .m_data      (m_data)
    );

endmodule

@@ test/tb.sv @@
// testbench for the 4-bit rgb dither block: random and directed transactions, scoreboard check
// depends on rgbd_pkg and rgb_four_bit_dither_top
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rgbd_pkg::*;

    localparam int MAXW = MAX_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    // scoreboard holding its own copy of the dither state
    class dither_scoreboard;
        logic [1:0] mode;
        logic [9:0] width;
        logic [1:0] phase;
        logic       sel;
        int         err_r [2*MAXW];
        int         err_g [2*MAXW];
        int         err_b [2*MAXW];
        out_t       pending [$];
        int         mismatches;

        function void reset_state();
            mode = MODE_NONE;
            width = LINE_WIDTH_RST;
            phase = 0;
            sel = 0;
            mismatches = 0;
            clear_store();
        endfunction

        function void clear_store();
            for (int i = 0; i < 2*MAXW; i++) begin
                err_r[i] = 0;
                err_g[i] = 0;
                err_b[i] = 0;
            end
        endfunction

        function void write_reg(logic idx, logic [9:0] val);
            if (idx == REG_DITHER_MODE) mode = val[1:0];
            else width = val;
        endfunction

        static function int clip_err(int v);
            int hi;
            hi = (1 << (ERROR_BITS_DEF - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        // error diffusion for one channel; int division truncates toward zero
        function logic [3:0] diffuse(ref int st [2*MAXW], input int col, input int v);
            int cur, nxt, e, q, res;
            bit inside_store, right;
            inside_store = col < MAXW;
            cur = sel ? MAXW : 0;
            nxt = sel ? 0 : MAXW;
            e = v + (inside_store ? st[cur + col] : 0);
            if (e < 0) q = 0;
            else begin
                q = e / 16;
                if (q > 15) q = 15;
            end
            res = e - q * 16;
            if (inside_store) begin
                right = (col + 1 < int'(width)) && (col + 1 < MAXW);
                if (right) st[cur+col+1] = clip_err(st[cur+col+1] + res * 7 / 16);
                if (col > 0) st[nxt+col-1] = clip_err(st[nxt+col-1] + res * 3 / 16);
                st[nxt+col] = clip_err(st[nxt+col] + res * 5 / 16);
                if (right) st[nxt+col+1] = clip_err(st[nxt+col+1] + res / 16);
            end
            return q[3:0];
        endfunction

        function logic [3:0] ordered(logic [7:0] v, logic [1:0] col);
            logic [4:0] q;
            q = {1'b0, v[7:4]};
            if (mode == MODE_BAYER && v[3:0] > BAYER_TABLE[phase][col]) q = q + 1;
            return q > 15 ? 4'd15 : q[3:0];
        endfunction

        // note an accepted input transaction
        function void note_input(in_t t);
            out_t o;
            int nb;
            case (t.opcode)
                OP_BEGIN_ROW: phase = t.row_index[1:0];
                OP_END_ROW: begin
                    if (mode == MODE_FS) begin
                        sel = ~sel;
                        nb = sel ? 0 : MAXW;
                        for (int i = 0; i < MAXW; i++) begin
                            err_r[nb+i] = 0;
                            err_g[nb+i] = 0;
                            err_b[nb+i] = 0;
                        end
                    end
                end
                OP_SPRITE: begin
                    clear_store();
                    phase = 0;
                end
                default: begin
                    if (mode == MODE_FS) begin
                        o.red_out   = diffuse(err_r, t.column, t.red_in);
                        o.green_out = diffuse(err_g, t.column, t.green_in);
                        o.blue_out  = diffuse(err_b, t.column, t.blue_in);
                    end else begin
                        o.red_out   = ordered(t.red_in, t.column[1:0]);
                        o.green_out = ordered(t.green_in, t.column[1:0]);
                        o.blue_out  = ordered(t.blue_in, t.column[1:0]);
                    end
                    pending.push_back(o);
                end
            endcase
        endfunction

        // check a result transaction against the oldest expectation
        function void check_result(out_t got);
            out_t exp_o;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_o = pending.pop_front();
            if (got.red_out !== exp_o.red_out || got.green_out !== exp_o.green_out ||
                got.blue_out !== exp_o.blue_out) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                             exp_o.red_out, exp_o.green_out, exp_o.blue_out,
                             got.red_out, got.green_out, got.blue_out);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    out_t m_data;
    logic cfg_we = 0;
    logic cfg_index = 0;
    logic [9:0] cfg_wdata = 0;

    dither_scoreboard sb;
    int  idle_cycles = 0;
    bit  stim_done = 0;
    bit  sink_hold = 0;   // slows the sink during the directed burst, alternating ready low and high

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    rgb_four_bit_dither_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // monitor: both handshakes are sampled at the edge, before the nonblocking updates land
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // result sink with random stalls
    initial begin
        int g;
        @(posedge aclk iff aresetn);
        forever begin
            g = sink_hold ? 1 : gap_len();
            if (g > 0) begin
                m_ready <= 0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
        end
    end

    // one input transaction: valid held until the handshake
    task automatic send_item(in_t t, bit with_gaps);
        int g;
        g = with_gaps ? gap_len() : 0;
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drop_valid();
        s_valid <= 0;
        @(posedge aclk);
    endtask

    // wait for the scoreboard to drain, then give the block time to finish a clear pass
    task automatic drain();
        drop_valid();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (2 * MAXW + 40) @(posedge aclk);
    endtask

    // registers are written only while the block is idle
    task automatic write_cfg(logic idx, logic [9:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        sb.write_reg(idx, val);
    endtask

    function automatic in_t make_item(logic [1:0] op, int col, int row,
                                      int r, int g, int b);
        in_t t;
        t.opcode = op;
        t.column = 9'(col);
        t.row_index = 12'(row);
        t.red_in = 8'(r);
        t.green_in = 8'(g);
        t.blue_in = 8'(b);
        return t;
    endfunction

    function automatic in_t rand_pixel(int col);
        return make_item(OP_PIXEL, col, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // a sprite: start, rows of pixels framed by begin and end row, with some noise
    task automatic send_sprite(int w, int rows, int noise_pct);
        send_item(make_item(OP_SPRITE, $urandom, $urandom, $urandom, $urandom, $urandom), 1);
        for (int y = 0; y < rows; y++) begin
            send_item(make_item(OP_BEGIN_ROW, $urandom, y + ($urandom_range(0, 1) << 4),
                                $urandom, $urandom, $urandom), 1);
            for (int x = 0; x < w; x++) begin
                if ($urandom_range(0, 99) < noise_pct)
                    send_item(make_item(2'($urandom), $urandom, $urandom, $urandom,
                                        $urandom, $urandom), 1);
                else
                    send_item(rand_pixel(x), 1);
            end
            send_item(make_item(OP_END_ROW, $urandom, $urandom, $urandom, $urandom,
                                $urandom), 1);
        end
    endtask

    initial begin
        int sent;
        logic [9:0] widths [5];
        sb = new();
        sb.reset_state();
        widths = '{10'd1, 10'd4, 10'd16, 10'd512, 10'd1023};
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // reset clears the whole store before input is taken
        repeat (2 * MAXW + 40) @(posedge aclk);

        // directed: field extremes in every mode, columns at both ends of the store, saturation
        for (int m = 0; m < 4; m++) begin
            write_cfg(REG_DITHER_MODE, 10'(m));
            write_cfg(REG_LINE_WIDTH, m == 3 ? 10'd0 : 10'd512);
            send_item(make_item(OP_SPRITE, 0, 0, 0, 0, 0), 0);
            send_item(make_item(OP_BEGIN_ROW, 0, 12'hfff, 0, 0, 0), 0);
            send_item(make_item(OP_PIXEL, 0, 0, 8'h00, 8'hff, 8'h0f), 0);
            send_item(make_item(OP_PIXEL, 1, 0, 8'hff, 8'hff, 8'hff), 0);
            send_item(make_item(OP_PIXEL, 511, 12'hfff, 8'hf8, 8'h07, 8'h80), 0);
            send_item(make_item(OP_PIXEL, 510, 0, 8'h00, 8'h00, 8'h00), 0);
            send_item(make_item(OP_END_ROW, 0, 0, 0, 0, 0), 0);
            send_item(make_item(OP_PIXEL, 510, 0, 8'h01, 8'hfe, 8'h7f), 0);
            drain();
        end

        // sender holds off while the sink runs slowly on a burst of pixels
        write_cfg(REG_DITHER_MODE, 10'(MODE_FS));
        write_cfg(REG_LINE_WIDTH, 10'd4);
        sink_hold = 1;
        for (int i = 0; i < 6; i++) send_item(rand_pixel(i % 4), 0);
        drop_valid();
        repeat (80) @(posedge aclk);
        sink_hold = 0;
        drain();

        // random part: sprites under several settings, mostly well formed
        sent = 0;
        while (sent < 1500) begin
            int w, rows, mode_sel;
            mode_sel = $urandom_range(0, 3);
            write_cfg(REG_DITHER_MODE, 10'(mode_sel));
            write_cfg(REG_LINE_WIDTH, widths[$urandom_range(0, 4)]);
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            rows = $urandom_range(1, 5);
            send_sprite(w, rows, 10);
            sent += rows * (w + 2) + 1;
            // some fully random traffic, including saturating dark and bright runs
            for (int i = 0; i < 20; i++) begin
                if ($urandom_range(0, 1))
                    send_item(make_item(OP_PIXEL, $urandom_range(0, 3), 0,
                                        $urandom_range(0, 1) ? 8'hff : 8'h00,
                                        $urandom_range(0, 1) ? 8'hff : 8'h00,
                                        $urandom), 1);
                else
                    send_item(make_item(2'($urandom), $urandom, $urandom, $urandom,
                                        $urandom, $urandom), 1);
            end
            sent += 20;
            // pause until every expected result has come before changing settings
            drain();
        end

        stim_done = 1;
        drop_valid();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
